### hw/rtl/midi_note_gate_parser_core_macros.svh
// Assertion macros shared by the MIDI note gate parser RTL
`ifndef MIDI_NOTE_GATE_PARSER_CORE_MACROS_SVH
`define MIDI_NOTE_GATE_PARSER_CORE_MACROS_SVH

// same-cycle implication, sampled on clock, off while reset is high
`define MNGP_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off while reset is high
`define MNGP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/mngp_pkg.sv
// Constants, types and the CC1 scaling table of the MIDI note gate parser
package mngp_pkg;

   localparam logic [7:0] STATUS_CLOCK    = 8'hF8;
   localparam logic [3:0] KIND_NOTE_OFF   = 4'h8;
   localparam logic [3:0] KIND_NOTE_ON    = 4'h9;
   localparam logic [3:0] KIND_CTRL       = 4'hB;
   localparam logic [6:0] CC_MODWHEEL     = 7'd1;
   localparam logic [6:0] CC_SUSTAIN      = 7'd64;
   localparam logic [6:0] SUSTAIN_ON      = 7'd64;
   localparam logic [6:0] NOTE_CENTRE     = 7'd60;
   localparam logic [6:0] NOTE_LOW_CLAMP  = 7'd12;   // centre minus limit
   localparam logic [6:0] NOTE_HIGH_CLAMP = 7'd108;  // centre plus limit
   localparam logic [6:0] TRANSPOSE_MIN   = 7'h50;   // -48
   localparam logic [6:0] TRANSPOSE_MAX   = 7'h30;   // +48

   localparam int NOTE_COUNT        = 128;
   localparam int CSR_ADDR_WIDTH    = 3;
   localparam int CSR_DATA_WIDTH    = 32;
   localparam int REQ_TDATA_WIDTH   = 8;
   localparam int RSP_TDATA_WIDTH   = 40;

   // register index, taken from paddr[2]
   localparam logic REG_LISTEN_CHANNEL = 1'b0;

   typedef struct packed {
      logic        pad;
      logic        control_touched;
      logic [19:0] control_target;
      logic        sustain_down;
      logic [7:0]  held_count;
      logic        gate_open;
      logic        gate_enabled;
      logic [6:0]  transpose;
   } rsp_fields_type;

   typedef logic [19:0] cc_table_type [0:NOTE_COUNT-1];

   // CC1 value scaled to 0..4095 in Q8, worked out at elaboration
   function automatic cc_table_type build_cc_table();
      cc_table_type t;
      for (int i = 0; i < NOTE_COUNT; i++) begin
         t[i] = 20'((i * 4095 * 256) / 127);
      end
      return t;
   endfunction

   localparam cc_table_type CC_TARGET_TABLE = build_cc_table();

endpackage

### hw/rtl/midi_note_gate_parser_core.sv
// MIDI note gate parser: running status, held-note map, gate, transpose and CC1 target
//
// Requests arrive one MIDI byte each on req_tdata; every accepted byte yields
// exactly one result on rsp_tdata carrying the state after that byte.
// The byte is first held in an input stage, then one pass of logic updates
// the parser state and loads the result register; one byte is taken every
// cycle while the receiver is not stalling.
// The held-note map is 128 flip-flops read and written at one note per byte.
// listen_channel sits at csr byte address 0; the user must write it only while
// idle, which the block itself does not enforce; pready is always high.
// A synchronous reset clears the note map, counters and running status,
// opens the gate state and empties both stages.
// When the receiver stalls, the result register holds and the input stage
// keeps one further byte; req_tready then drops until the result is taken.
`include "midi_note_gate_parser_core_macros.svh"

module midi_note_gate_parser_core (
   input  logic                                    clock,
   input  logic                                    reset,
   // request: [7:0] midi_byte
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic [mngp_pkg::REQ_TDATA_WIDTH-1:0]    req_tdata,
   // result: [6:0] transpose, [7] gate_enabled, [8] gate_open, [16:9] held_count,
   // [17] sustain_down, [37:18] control_target, [38] control_touched, [39] zero
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   output logic [mngp_pkg::RSP_TDATA_WIDTH-1:0]    rsp_tdata,
   // configuration
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [mngp_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  logic [mngp_pkg::CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [mngp_pkg::CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                                    csr_pready
);
   import mngp_pkg::*;

   // configuration
   logic [3:0]            listen_channel_ff;
   logic                  csr_write;

   // input stage
   logic                  s1_valid_ff, s1_valid_in;
   logic [7:0]            s1_byte_ff;
   logic                  req_accept;
   logic                  advance;
   logic                  fire;

   // parser state
   logic [7:0]            running_status_ff, running_status_in;
   logic                  data_index_ff, data_index_in;
   logic [6:0]            first_data_ff, first_data_in;
   logic [NOTE_COUNT-1:0] note_held_ff, note_held_in;
   logic [7:0]            held_total_ff, held_total_in;
   logic                  pedal_down_ff, pedal_down_in;
   logic                  gate_seen_ff, gate_seen_in;
   logic                  gate_state_ff, gate_state_in;
   logic [6:0]            transpose_ff, transpose_in;
   logic [19:0]           control_ff, control_in;
   logic                  touched;

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_fields_type        rsp_data_ff, rsp_data_in;

   // pair decode helpers
   logic [3:0]            kind;
   logic [6:0]            data_byte;
   logic                  channel_kind;
   logic                  pair_done;
   logic                  note_is_held;
   logic [7:0]            note_offset;
   logic [6:0]            clamped_transpose;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_LISTEN_CHANNEL);
   assign csr_prdata = (csr_paddr[2] == REG_LISTEN_CHANNEL) ?
                       {{(CSR_DATA_WIDTH-4){1'b0}}, listen_channel_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_channel_ff <= '0;
      end else if (csr_write) begin
         listen_channel_ff <= csr_pwdata[3:0];
      end
   end

   // handshake: the result register frees the input stage, which frees the request side
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && advance;
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // decode
   assign kind         = running_status_ff[7:4];
   assign data_byte    = s1_byte_ff[6:0];
   assign channel_kind = (kind == KIND_NOTE_OFF) || (kind == KIND_NOTE_ON) ||
                         (kind == KIND_CTRL);
   assign pair_done    = channel_kind && data_index_ff &&
                         (running_status_ff[3:0] == listen_channel_ff);
   assign note_is_held = note_held_ff[first_data_ff];
   assign note_offset  = {1'b0, first_data_ff} - {1'b0, NOTE_CENTRE};

   always_comb begin
      if (first_data_ff < NOTE_LOW_CLAMP) begin
         clamped_transpose = TRANSPOSE_MIN;
      end else if (first_data_ff > NOTE_HIGH_CLAMP) begin
         clamped_transpose = TRANSPOSE_MAX;
      end else begin
         clamped_transpose = note_offset[6:0];
      end
   end

   always_comb begin
      running_status_in = running_status_ff;
      data_index_in     = data_index_ff;
      first_data_in     = first_data_ff;
      note_held_in      = note_held_ff;
      held_total_in     = held_total_ff;
      pedal_down_in     = pedal_down_ff;
      gate_seen_in      = gate_seen_ff;
      gate_state_in     = gate_state_ff;
      transpose_in      = transpose_ff;
      control_in        = control_ff;
      touched           = 1'b0;

      if (s1_byte_ff == STATUS_CLOCK) begin
         // clock byte: hold everything
      end else if (s1_byte_ff[7]) begin
         running_status_in = s1_byte_ff;
         data_index_in     = 1'b0;
      end else if (channel_kind) begin
         if (!data_index_ff) begin
            first_data_in = data_byte;
            data_index_in = 1'b1;
         end else begin
            data_index_in = 1'b0;
            if (pair_done) begin
               if ((kind == KIND_NOTE_ON) && (data_byte != 7'd0)) begin
                  transpose_in = clamped_transpose;
                  if (!note_is_held) begin
                     note_held_in[first_data_ff] = 1'b1;
                     held_total_in = held_total_ff + 8'd1;
                  end
                  gate_seen_in  = 1'b1;
                  gate_state_in = 1'b1;
               end else if ((kind == KIND_NOTE_OFF) || (kind == KIND_NOTE_ON)) begin
                  if (note_is_held) begin
                     note_held_in[first_data_ff] = 1'b0;
                     if (held_total_ff != 8'd0) begin
                        held_total_in = held_total_ff - 8'd1;
                     end
                  end
                  gate_seen_in  = 1'b1;
                  gate_state_in = (held_total_in != 8'd0) || pedal_down_ff;
               end else if (first_data_ff == CC_MODWHEEL) begin
                  control_in = CC_TARGET_TABLE[data_byte];
                  touched    = 1'b1;
               end else if (first_data_ff == CC_SUSTAIN) begin
                  pedal_down_in = (data_byte >= SUSTAIN_ON);
                  gate_seen_in  = 1'b1;
                  gate_state_in = (held_total_ff != 8'd0) || pedal_down_in;
               end
            end
         end
      end
   end

   always_comb begin
      rsp_data_in                 = '0;
      rsp_data_in.transpose       = transpose_in;
      rsp_data_in.gate_enabled    = gate_seen_in;
      rsp_data_in.gate_open       = gate_state_in;
      rsp_data_in.held_count      = held_total_in;
      rsp_data_in.sustain_down    = pedal_down_in;
      rsp_data_in.control_target  = control_in;
      rsp_data_in.control_touched = touched;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         running_status_ff <= '0;
         data_index_ff     <= 1'b0;
         first_data_ff     <= '0;
         note_held_ff      <= '0;
         held_total_ff     <= '0;
         pedal_down_ff     <= 1'b0;
         gate_seen_ff      <= 1'b0;
         gate_state_ff     <= 1'b1;
         transpose_ff      <= '0;
         control_ff        <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            running_status_ff <= running_status_in;
            data_index_ff     <= data_index_in;
            first_data_ff     <= first_data_in;
            note_held_ff      <= note_held_in;
            held_total_ff     <= held_total_in;
            pedal_down_ff     <= pedal_down_in;
            gate_seen_ff      <= gate_seen_in;
            gate_state_ff     <= gate_state_in;
            transpose_ff      <= transpose_in;
            control_ff        <= control_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_byte_ff <= req_tdata;
      end
      if (fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `MNGP_ASSERT_IMPLIES(a_held_count_matches_map, 1'b1,
      $countones(note_held_ff) == int'(held_total_ff), "held count differs from note map")
   `MNGP_ASSERT_IMPLIES(a_closed_gate_is_idle, !gate_state_ff,
      (held_total_ff == 8'd0) && !pedal_down_ff, "gate closed with notes or pedal down")
   `MNGP_ASSERT_IMPLIES(a_no_pair_without_status, !channel_kind,
      !data_index_ff, "half pair collected without channel status")
   `MNGP_ASSERT_NEXT(a_fire_loads_result, fire,
      rsp_valid_ff, "processed request did not load the result register")

endmodule
